>>> src/scik_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the SCARA
// inverse kinematics block. No dependencies; compile first.
package scik_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TAB_LEN           = 24;

  // Field widths
  localparam int COORD_W  = 32;
  localparam int LEN_W    = 31;
  localparam int SHOULD_W = 20;
  localparam int ELBOW_W  = 18;
  localparam int IDX_W    = 2;

  // Datapath widths
  localparam int MAG_W    = 64;
  localparam int NORM_W   = 30;
  localparam int NORM_MSB = 29;
  localparam int CX_W     = 34;
  localparam int ANG_W    = 28;
  localparam int DIV_BITS = 30;
  localparam int SQRT_BITS = 31;
  localparam int REM_W    = 35;

  // Constants
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(65536);
  localparam logic [30:0]      ONE_Q30   = 31'h4000_0000;
  localparam logic [60:0]      ONE_Q60   = 61'h1000_0000_0000_0000;
  localparam int PI_Q24       = 52707179;
  localparam int ELBOW_MAX    = 205887;
  localparam int SHOULDER_MAX = 411775;
  localparam int ROUND_HALF   = 128;
  localparam int ROUND_SHIFT  = 8;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_UPPER_ARM = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FOREARM   = IDX_W'(1);

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
  } target_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  lift_position;
    logic signed [SHOULD_W-1:0] shoulder_angle;
    logic [ELBOW_W-1:0]         elbow_angle;
    logic                       out_of_reach;
  } joints_t;

  // Sideband that rides along the front of the pipeline
  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [LEN_W-1:0]   a1;
    logic [LEN_W-1:0]   a2;
    logic               xn;
    logic               yn;
    logic [COORD_W-1:0] mx;
    logic [COORD_W-1:0] my;
    logic               cneg;
    logic               flag;
    logic [30:0]        cmag;
    logic [30:0]        s;
  } side_t;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic               flag;
    logic [ELBOW_W-1:0] elbow;
  } tail_t;

  // atan(2^-i) in Q.24 radians
  function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = ANG_W'(13176795);
      1:  v = ANG_W'(7778716);
      2:  v = ANG_W'(4110060);
      3:  v = ANG_W'(2086331);
      4:  v = ANG_W'(1047214);
      5:  v = ANG_W'(524117);
      6:  v = ANG_W'(262123);
      7:  v = ANG_W'(131069);
      8:  v = ANG_W'(65536);
      9:  v = ANG_W'(32768);
      10: v = ANG_W'(16384);
      11: v = ANG_W'(8192);
      12: v = ANG_W'(4096);
      13: v = ANG_W'(2048);
      14: v = ANG_W'(1024);
      15: v = ANG_W'(512);
      16: v = ANG_W'(256);
      17: v = ANG_W'(128);
      18: v = ANG_W'(64);
      19: v = ANG_W'(32);
      20: v = ANG_W'(16);
      21: v = ANG_W'(8);
      22: v = ANG_W'(4);
      23: v = ANG_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> src/scik_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from scik_pkg at the instantiation site.
interface scik_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/scik_cordic.sv
// Pipelined vectoring CORDIC atan2 on sign/magnitude operands, Q.24 output.
// Depends on scik_pkg. Advances on en.
module scik_cordic
  import scik_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    yneg,
  input  logic [MAG_W-1:0]        ym,
  input  logic                    xneg,
  input  logic [MAG_W-1:0]        xm,
  output logic signed [ANG_W-1:0] angle
);

  // Stage 1: locate the leading one of the combined magnitude
  logic [MAG_W-1:0] mag_or;
  logic [5:0]       pos_c;
  logic [MAG_W-1:0] n1_xm, n1_ym;
  logic [5:0]       n1_pos;
  logic             n1_zero, n1_yneg, n1_xneg;

  always_comb begin
    mag_or = xm | ym;
    pos_c  = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag_or[i]) pos_c = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_xm   <= xm;
      n1_ym   <= ym;
      n1_pos  <= pos_c;
      n1_zero <= (mag_or == '0);
      n1_yneg <= yneg;
      n1_xneg <= xneg;
    end
  end

  // Stage 2: scale so the larger magnitude lands in [2^29, 2^30)
  logic [5:0]        sh;
  logic [MAG_W-1:0]  xs_w, ys_w;
  logic [NORM_W-1:0] n2_xs, n2_ys;
  logic              n2_zero, n2_yneg, n2_xneg;

  always_comb begin
    if (n1_pos >= 6'(NORM_MSB)) begin
      sh   = n1_pos - 6'(NORM_MSB);
      xs_w = n1_xm >> sh;
      ys_w = n1_ym >> sh;
    end else begin
      sh   = 6'(NORM_MSB) - n1_pos;
      xs_w = n1_xm << sh;
      ys_w = n1_ym << sh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_xs   <= xs_w[NORM_W-1:0];
      n2_ys   <= ys_w[NORM_W-1:0];
      n2_zero <= n1_zero;
      n2_yneg <= n1_yneg;
      n2_xneg <= n1_xneg;
    end
  end

  // Stage 3: apply signs, fold the left half plane onto the right
  logic signed [CX_W-1:0]  cx [0:STAGES];
  logic signed [CX_W-1:0]  cy [0:STAGES];
  logic signed [ANG_W-1:0] cz [0:STAGES];
  logic                    cz_zero [0:STAGES];
  logic signed [CX_W-1:0]  y_init;

  always_comb begin
    y_init = $signed(CX_W'(n2_ys));
    if (n2_yneg ^ n2_xneg) y_init = -y_init;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]      <= $signed(CX_W'(n2_xs));
      cy[0]      <= y_init;
      cz_zero[0] <= n2_zero;
      if (!n2_xneg) cz[0] <= '0;
      else if (n2_yneg) cz[0] <= -ANG_W'(PI_Q24);
      else cz[0] <= ANG_W'(PI_Q24);
    end
  end

  // Micro-rotations, one per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        cz_zero[i+1] <= cz_zero[i];
        if (!cy[i][CX_W-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_entry(i);
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_entry(i);
        end
      end
    end
  end

  // atan2(0, 0) is zero
  assign angle = cz_zero[STAGES] ? '0 : cz[STAGES];

endmodule

>>> src/scara_inverse_kinematics.sv
// SCARA inverse kinematics: target (x, y, z) in, lift, shoulder, elbow out.
// Throughput: one transaction per cycle while the output queue has room; the
// divider, square root and three CORDIC units are fully unrolled, and a two-entry output queue absorbs stalls.
// Reset: synchronous; clears the pipeline and queue, both link lengths to 1.0.
// Depends on scik_pkg, scik_stream_if and scik_cordic.
module scara_inverse_kinematics
  import scik_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              write_en,
  input  logic [IDX_W-1:0]  reg_index,
  input  logic [LEN_W-1:0]  write_data,
  scik_stream_if.sink       target,
  scik_stream_if.source     joints
);

  localparam int CL    = CORDIC_STAGES + 3;
  localparam int PRE   = 71;
  localparam int ST_X  = PRE - 1;
  localparam int LAT   = PRE + CL + 2;

  // Configuration registers
  logic [LEN_W-1:0] upper_arm_length, forearm_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_arm_length <= LEN_RESET;
      forearm_length   <= LEN_RESET;
    end else if (write_en) begin
      if (reg_index == REG_UPPER_ARM) upper_arm_length <= write_data;
      if (reg_index == REG_FOREARM)   forearm_length   <= write_data;
    end
  end

  // Flow control: advance whenever the output queue has room
  logic [1:0]     fcount;
  logic           en, accept, push, pop;
  logic [LAT-1:0] vld;

  assign en           = (fcount != 2'd2);
  assign target.ready = en;
  assign accept       = target.valid && en;
  assign push         = en && vld[LAT-1];
  assign pop          = joints.valid && joints.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  // Sideband pipeline with per-stage field updates
  side_t side_pipe [0:PRE-1];
  side_t side_next [0:PRE-1];
  side_t side_in;
  logic  [COORD_W-1:0] tx, ty;

  always_comb begin
    tx = target.payload.target_x;
    ty = target.payload.target_y;
    side_in      = '0;
    side_in.z    = target.payload.target_z;
    side_in.a1   = upper_arm_length;
    side_in.a2   = forearm_length;
    side_in.xn   = tx[COORD_W-1];
    side_in.yn   = ty[COORD_W-1];
    side_in.mx   = tx[COORD_W-1] ? (~tx + 1'b1) : tx;
    side_in.my   = ty[COORD_W-1] ? (~ty + 1'b1) : ty;
  end

  // Front end: squares, sums, difference
  logic [63:0] pr_mx2, pr_my2, pr_a12, pr_a22, pr_a1a2;
  logic [63:0] sm_p, sm_q, sm_den;
  logic [63:0] df_diff, df_den;
  logic        cneg_c, flag_c, one_c;
  logic [62:0] d_num [0:DIV_BITS];
  logic [62:0] d_den [0:DIV_BITS];
  logic [DIV_BITS-1:0] d_q [0:DIV_BITS];
  logic        d_one [0:DIV_BITS];
  logic [30:0] cmag_c;
  logic [60:0] cm2;
  logic [61:0] sq_val  [0:SQRT_BITS];
  logic [REM_W-1:0] sq_rem [0:SQRT_BITS];
  logic [30:0] sq_root [0:SQRT_BITS];
  logic [61:0] am_as, am_bm;
  logic [60:0] amag;
  logic [62:0] xm_c;
  logic        xneg_c;
  logic [62:0] cx_xm;
  logic        cx_xneg;
  logic [61:0] cx_as;

  assign cneg_c = sm_p < sm_q;
  assign flag_c = (df_den == '0) || (df_diff > df_den);
  assign one_c  = flag_c || (df_diff == df_den);
  assign cmag_c = d_one[DIV_BITS] ? ONE_Q30 : {1'b0, d_q[DIV_BITS]};

  // Second leg of the elbow triangle
  always_comb begin
    amag = {side_pipe[ST_X-1].a1, 30'd0};
    if (!side_pipe[ST_X-1].cneg) begin
      xm_c   = 63'(amag) + 63'(am_bm);
      xneg_c = 1'b0;
    end else if (62'(amag) >= am_bm) begin
      xm_c   = 63'(62'(amag) - am_bm);
      xneg_c = 1'b0;
    end else begin
      xm_c   = 63'(am_bm - 62'(amag));
      xneg_c = 1'b1;
    end
  end

  // Shift the sideband and fill in each field at the stage that computes it
  always_comb begin
    side_next[0] = side_in;
    for (int k = 1; k < PRE; k++) side_next[k] = side_pipe[k-1];
    side_next[3].cneg  = cneg_c;
    side_next[4].flag  = flag_c;
    side_next[35].cmag = cmag_c;
    side_next[69].s    = sq_root[SQRT_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < PRE; k++) side_pipe[k] <= side_next[k];

      pr_mx2  <= 64'(side_pipe[0].mx) * 64'(side_pipe[0].mx);
      pr_my2  <= 64'(side_pipe[0].my) * 64'(side_pipe[0].my);
      pr_a12  <= 64'(side_pipe[0].a1) * 64'(side_pipe[0].a1);
      pr_a22  <= 64'(side_pipe[0].a2) * 64'(side_pipe[0].a2);
      pr_a1a2 <= 64'(side_pipe[0].a1) * 64'(side_pipe[0].a2);

      sm_p   <= pr_mx2 + pr_my2;
      sm_q   <= pr_a12 + pr_a22;
      sm_den <= {pr_a1a2[62:0], 1'b0};

      df_diff <= cneg_c ? (sm_q - sm_p) : (sm_p - sm_q);
      df_den  <= sm_den;

      d_num[0] <= one_c ? '0 : df_diff[62:0];
      d_den[0] <= df_den[62:0];
      d_q[0]   <= '0;
      d_one[0] <= one_c;

      cm2 <= 61'(62'(side_pipe[35].cmag) * 62'(side_pipe[35].cmag));

      sq_val[0]  <= {1'b0, ONE_Q60 - cm2};
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;

      am_as <= 62'(side_pipe[68].a2) * 62'(sq_root[SQRT_BITS]);
      am_bm <= 62'(side_pipe[68].a2) * 62'(side_pipe[68].cmag);

      cx_xm   <= xm_c;
      cx_xneg <= xneg_c;
      cx_as   <= am_as;
    end
  end

  // Restoring fraction divider, one quotient bit per stage
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    logic [63:0] twice;
    assign twice = {d_num[j], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        d_den[j+1] <= d_den[j];
        d_one[j+1] <= d_one[j];
        if (twice >= {1'b0, d_den[j]}) begin
          d_num[j+1] <= 63'(twice - {1'b0, d_den[j]});
          d_q[j+1]   <= {d_q[j][DIV_BITS-2:0], 1'b1};
        end else begin
          d_num[j+1] <= twice[62:0];
          d_q[j+1]   <= {d_q[j][DIV_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // Digit-by-digit square root, one root bit per stage
  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh, trial;
    assign rem_sh = REM_W'({sq_rem[k], sq_val[k][61-2*k -: 2]});
    assign trial  = REM_W'({sq_root[k], 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        sq_val[k+1] <= sq_val[k];
        if (rem_sh >= trial) begin
          sq_rem[k+1]  <= rem_sh - trial;
          sq_root[k+1] <= {sq_root[k][29:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= rem_sh;
          sq_root[k+1] <= {sq_root[k][29:0], 1'b0};
        end
      end
    end
  end

  // Three angle units in parallel
  logic signed [ANG_W-1:0] z_elbow, z_alpha, z_beta;

  scik_cordic #(.STAGES(CORDIC_STAGES)) u_elbow (
    .clk   (clk),
    .en    (en),
    .yneg  (1'b0),
    .ym    (MAG_W'(side_pipe[ST_X].s)),
    .xneg  (side_pipe[ST_X].cneg),
    .xm    (MAG_W'(side_pipe[ST_X].cmag)),
    .angle (z_elbow)
  );

  scik_cordic #(.STAGES(CORDIC_STAGES)) u_alpha (
    .clk   (clk),
    .en    (en),
    .yneg  (1'b0),
    .ym    (MAG_W'(cx_as)),
    .xneg  (cx_xneg),
    .xm    (MAG_W'(cx_xm)),
    .angle (z_alpha)
  );

  scik_cordic #(.STAGES(CORDIC_STAGES)) u_beta (
    .clk   (clk),
    .en    (en),
    .yneg  (side_pipe[ST_X].xn),
    .ym    (MAG_W'(side_pipe[ST_X].mx)),
    .xneg  (side_pipe[ST_X].yn),
    .xm    (MAG_W'(side_pipe[ST_X].my)),
    .angle (z_beta)
  );

  // Carry lift and flag alongside the angle units
  tail_t tl [1:CL];

  always_ff @(posedge clk) begin
    if (en) begin
      tl[1].z     <= side_pipe[ST_X].z;
      tl[1].flag  <= side_pipe[ST_X].flag;
      tl[1].elbow <= '0;
      for (int j = 2; j <= CL; j++) tl[j] <= tl[j-1];
    end
  end

  // Round to Q.16 (shoulder signed Q4.16, elbow unsigned Q2.16) and saturate
  logic signed [ANG_W:0]   el_sum, el_rnd;
  logic signed [ANG_W:0]   sh_diff;
  logic signed [ANG_W+1:0] sh_sum, sh_rnd;
  logic [ELBOW_W-1:0]      el_clamp;
  logic signed [SHOULD_W-1:0] sh_clamp;
  tail_t r1_tail;
  logic signed [ANG_W:0]   r1_shd;
  joints_t                 r2_res;

  always_comb begin
    el_sum = {z_elbow[ANG_W-1], z_elbow} + (ANG_W+1)'(ROUND_HALF);
    el_rnd = el_sum >>> ROUND_SHIFT;
    if (el_rnd < 0) el_clamp = '0;
    else if (el_rnd > ELBOW_MAX) el_clamp = ELBOW_W'(ELBOW_MAX);
    else el_clamp = el_rnd[ELBOW_W-1:0];

    sh_diff = {z_beta[ANG_W-1], z_beta} - {z_alpha[ANG_W-1], z_alpha};
    sh_sum  = {r1_shd[ANG_W], r1_shd} + (ANG_W+2)'(ROUND_HALF);
    sh_rnd  = sh_sum >>> ROUND_SHIFT;
    if (sh_rnd > SHOULDER_MAX) sh_clamp = SHOULD_W'(SHOULDER_MAX);
    else if (sh_rnd < -SHOULDER_MAX) sh_clamp = -SHOULD_W'(SHOULDER_MAX);
    else sh_clamp = sh_rnd[SHOULD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_tail.z     <= tl[CL].z;
      r1_tail.flag  <= tl[CL].flag;
      r1_tail.elbow <= el_clamp;
      r1_shd        <= sh_diff;

      r2_res.lift_position  <= r1_tail.z;
      r2_res.shoulder_angle <= sh_clamp;
      r2_res.elbow_angle    <= r1_tail.elbow;
      r2_res.out_of_reach   <= r1_tail.flag;
    end
  end

  // Two-entry output queue
  joints_t q0, q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount <= '0;
    end else begin
      case ({push, pop})
        2'b10:   fcount <= fcount + 2'd1;
        2'b01:   fcount <= fcount - 2'd1;
        default: fcount <= fcount;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (fcount == 2'd0) q0 <= r2_res;
        else q1 <= r2_res;
      end
      2'b01: q0 <= q1;
      2'b11: begin
        if (fcount == 2'd1) q0 <= r2_res;
        else begin
          q0 <= q1;
          q1 <= r2_res;
        end
      end
      default: q0 <= q0;
    endcase
  end

  assign joints.valid   = (fcount != 2'd0);
  assign joints.payload = q0;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fcount != 2'd3) else $error("output queue count out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld)) else $error("pipeline moved while stalled");

  a_elbow_range: assert property (@(posedge clk) disable iff (rst)
    joints.valid |-> joints.payload.elbow_angle <= ELBOW_W'(ELBOW_MAX))
    else $error("elbow angle beyond pi");

  a_shoulder_range: assert property (@(posedge clk) disable iff (rst)
    joints.valid |-> ($signed(joints.payload.shoulder_angle) <= SHOULDER_MAX &&
                      $signed(joints.payload.shoulder_angle) >= -SHOULDER_MAX))
    else $error("shoulder angle out of range");
`endif

endmodule
